@@ rtl/dwsp_pkg.sv @@
// Shared types and constants of the dual wheel speed controller.
// Used by the serial multiplier, the serial divider and the top level.
// No dependencies.
`default_nettype none

package dwsp_pkg;

   // Field widths.
   localparam int CNT_W  = 32;
   localparam int TGT_W  = 20;
   localparam int MS_W   = 16;
   localparam int GAIN_W = 32;
   localparam int LIM_W  = 16;
   localparam int DRV_W  = 17;
   localparam int DUTY_W = 8;
   localparam int DIR_W  = 2;
   localparam int SPD_W  = 20;
   localparam int ERR_W  = 21;
   localparam int ACC_W  = 48;
   localparam int TERM_W = 64;
   localparam int CSR_W  = 3;

   // Shared serial units.
   localparam int MUL_A_W   = 48;
   localparam int MUL_B_W   = 32;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);
   localparam int DIV_N_W   = 64;
   localparam int DIV_D_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // Fixed-point constants.
   localparam int                 Q25_SHIFT = 25;
   localparam logic [31:0]        SPEED_NUM = 32'd15360000;
   localparam logic [SPD_W-1:0]   SPEED_MAX = 20'd524287;
   localparam logic [DUTY_W-1:0]  DUTY_FULL = 8'd255;
   localparam logic signed [49:0] ACC_SAT_HI = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [49:0] ACC_SAT_LO = 50'sh3_8000_0000_0001;
   localparam logic [MUL_P_W-1:0] TERM_MAX   = MUL_P_W'(64'h1000_0000_0000_0000);

   // Register indexes.
   localparam logic [CSR_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_W-1:0] CSR_DRIVE_LIM  = 3'd3;
   localparam logic [CSR_W-1:0] CSR_CPR_LEFT   = 3'd4;
   localparam logic [CSR_W-1:0] CSR_CPR_RIGHT  = 3'd5;

   // Bridge direction codes.
   localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
   localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEN,
      ST_NUM,
      ST_SPD,
      ST_ACC,
      ST_P,
      ST_I,
      ST_D,
      ST_DDIV,
      ST_SUM,
      ST_CLAMP,
      ST_DUTYM,
      ST_DUTYD,
      ST_NEXT,
      ST_OUT
   } dwsp_state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } dwsp_mul_req_type;

   typedef struct packed {
      logic               done;
      logic [MUL_P_W-1:0] prod;
   } dwsp_mul_rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] den;
   } dwsp_div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quo;
   } dwsp_div_rsp_type;

endpackage

`default_nettype wire

@@ rtl/dual_wheel_speed_pid_unit.sv @@
// Top level of the dual wheel PID speed controller: sequencer and wheel state.
// Depends on dwsp_pkg, dwsp_mul and dwsp_div.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  encoder counts, targets, elapsed ms
//   rsp      out        rsp_valid/rsp_stall  drive, duty, direction, speed per wheel
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// A request handles the wheels one after the other, each through seven 32-step
// multiplies and three 64-step divides on one shared bit-serial multiplier and
// one shared restoring divider.
// Reset is synchronous and clears the wheel state and the registers to defaults.
// A new request is taken only once the previous response has been taken;
// rsp_stall holds the response registers unchanged.
`default_nettype none

module dual_wheel_speed_pid_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire signed [dwsp_pkg::CNT_W-1:0]      req_enc_count_left,
   input  wire signed [dwsp_pkg::CNT_W-1:0]      req_enc_count_right,
   input  wire signed [dwsp_pkg::TGT_W-1:0]      req_target_rpm_left,
   input  wire signed [dwsp_pkg::TGT_W-1:0]      req_target_rpm_right,
   input  wire        [dwsp_pkg::MS_W-1:0]       req_elapsed_ms,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [dwsp_pkg::DRV_W-1:0]     rsp_drive_left,
   output logic signed [dwsp_pkg::DRV_W-1:0]     rsp_drive_right,
   output logic        [dwsp_pkg::DUTY_W-1:0]    rsp_duty_left,
   output logic        [dwsp_pkg::DUTY_W-1:0]    rsp_duty_right,
   output logic        [dwsp_pkg::DIR_W-1:0]     rsp_dir_left,
   output logic        [dwsp_pkg::DIR_W-1:0]     rsp_dir_right,
   output logic signed [dwsp_pkg::SPD_W-1:0]     rsp_speed_left,
   output logic signed [dwsp_pkg::SPD_W-1:0]     rsp_speed_right,
   input  wire                                   csr_wr_en,
   input  wire        [dwsp_pkg::CSR_W-1:0]      csr_index,
   input  wire        [dwsp_pkg::GAIN_W-1:0]     csr_wdata
);

   // Configuration registers.
   logic [dwsp_pkg::GAIN_W-1:0] prop_ff, prop_in;
   logic [dwsp_pkg::GAIN_W-1:0] igain_ff, igain_in;
   logic [dwsp_pkg::GAIN_W-1:0] deriv_ff, deriv_in;
   logic [dwsp_pkg::LIM_W-1:0]  limit_ff, limit_in;
   logic [dwsp_pkg::LIM_W-1:0]  cpr_l_ff, cpr_l_in;
   logic [dwsp_pkg::LIM_W-1:0]  cpr_r_ff, cpr_r_in;

   // Latched request.
   logic [dwsp_pkg::CNT_W-1:0] cnt_l_ff, cnt_l_in;
   logic [dwsp_pkg::CNT_W-1:0] cnt_r_ff, cnt_r_in;
   logic [dwsp_pkg::TGT_W-1:0] tgt_l_ff, tgt_l_in;
   logic [dwsp_pkg::TGT_W-1:0] tgt_r_ff, tgt_r_in;
   logic [dwsp_pkg::MS_W-1:0]  ms_ff, ms_in;

   // Per-wheel state.
   logic        [dwsp_pkg::CNT_W-1:0] last_cnt_ff [2];
   logic        [dwsp_pkg::CNT_W-1:0] last_cnt_in [2];
   logic signed [dwsp_pkg::ERR_W-1:0] last_err_ff [2];
   logic signed [dwsp_pkg::ERR_W-1:0] last_err_in [2];
   logic signed [dwsp_pkg::ACC_W-1:0] integ_ff [2];
   logic signed [dwsp_pkg::ACC_W-1:0] integ_in [2];

   // Sequencer and working registers.
   dwsp_pkg::dwsp_state_type          state_ff, state_in;
   logic                              issued_ff, issued_in;
   logic                              wheel_ff, wheel_in;
   logic        [31:0]                den_ff, den_in;
   logic        [55:0]                num_ff, num_in;
   logic signed [dwsp_pkg::SPD_W-1:0] speed_ff, speed_in;
   logic signed [dwsp_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic signed [dwsp_pkg::TERM_W-1:0] p_ff, p_in;
   logic signed [dwsp_pkg::TERM_W-1:0] i_ff, i_in;
   logic        [54:0]                dmag_ff, dmag_in;
   logic                              dneg_ff, dneg_in;
   logic signed [dwsp_pkg::TERM_W-1:0] d_ff, d_in;
   logic signed [dwsp_pkg::TERM_W-1:0] total_ff, total_in;
   logic                              clamp_ff, clamp_in;
   logic        [40:0]                mag_ff, mag_in;
   logic        [23:0]                dutyn_ff, dutyn_in;
   logic        [dwsp_pkg::DUTY_W-1:0] duty_ff, duty_in;

   // Response registers.
   logic signed [dwsp_pkg::DRV_W-1:0]  drv_l_ff, drv_l_in, drv_r_ff, drv_r_in;
   logic        [dwsp_pkg::DUTY_W-1:0] dty_l_ff, dty_l_in, dty_r_ff, dty_r_in;
   logic        [dwsp_pkg::DIR_W-1:0]  dir_l_ff, dir_l_in, dir_r_ff, dir_r_in;
   logic signed [dwsp_pkg::SPD_W-1:0]  spd_l_ff, spd_l_in, spd_r_ff, spd_r_in;

   // Shared units.
   dwsp_pkg::dwsp_mul_req_type mul_req;
   dwsp_pkg::dwsp_mul_rsp_type mul_rsp;
   dwsp_pkg::dwsp_div_req_type div_req;
   dwsp_pkg::dwsp_div_rsp_type div_rsp;

   // Values of the wheel being worked on.
   logic        [dwsp_pkg::CNT_W-1:0] cnt_sel;
   logic        [dwsp_pkg::TGT_W-1:0] tgt_sel;
   logic        [dwsp_pkg::LIM_W-1:0] cpr_sel, cpr_eff, lim_eff;
   logic        [dwsp_pkg::CNT_W-1:0] delta, delta_mag;
   logic                              delta_neg;
   logic signed [dwsp_pkg::ERR_W-1:0] err_w, le;
   logic        [dwsp_pkg::ERR_W-1:0] err_mag;
   logic signed [21:0]                esum, ediff;
   logic        [21:0]                esum_mag, ediff_mag;
   logic        [dwsp_pkg::ACC_W-1:0] acc_mag;
   logic        [dwsp_pkg::SPD_W-1:0] spd_mag;
   logic signed [49:0]                acc_add, acc_sum;
   logic        [dwsp_pkg::TERM_W-1:0] pm, im;
   logic signed [dwsp_pkg::TERM_W-1:0] lim64;
   logic        [dwsp_pkg::DRV_W-1:0] drv_mag;
   logic signed [dwsp_pkg::DRV_W-1:0] drv_w;
   logic        [dwsp_pkg::DIR_W-1:0] dir_w;
   logic                              mul_state, div_state, unit_done;

   dwsp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   dwsp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Operand selection for the current wheel.
   always_comb begin
      cnt_sel   = wheel_ff ? cnt_r_ff : cnt_l_ff;
      tgt_sel   = wheel_ff ? tgt_r_ff : tgt_l_ff;
      cpr_sel   = wheel_ff ? cpr_r_ff : cpr_l_ff;
      cpr_eff   = (cpr_sel == '0) ? dwsp_pkg::LIM_W'(1) : cpr_sel;
      lim_eff   = (limit_ff == '0) ? dwsp_pkg::LIM_W'(1) : limit_ff;
      delta     = cnt_sel - last_cnt_ff[wheel_ff];
      delta_neg = delta[dwsp_pkg::CNT_W-1];
      delta_mag = delta_neg ? (~delta + 1'b1) : delta;
      le        = last_err_ff[wheel_ff];
      err_w     = $signed({tgt_sel[dwsp_pkg::TGT_W-1], tgt_sel})
                - $signed({speed_ff[dwsp_pkg::SPD_W-1], speed_ff});
      err_mag   = err_w[dwsp_pkg::ERR_W-1] ? dwsp_pkg::ERR_W'(-err_w) : err_w;
      esum      = $signed({err_w[dwsp_pkg::ERR_W-1], err_w})
                + $signed({le[dwsp_pkg::ERR_W-1], le});
      ediff     = $signed({err_w[dwsp_pkg::ERR_W-1], err_w})
                - $signed({le[dwsp_pkg::ERR_W-1], le});
      esum_mag  = esum[21] ? 22'(-esum) : esum;
      ediff_mag = ediff[21] ? 22'(-ediff) : ediff;
      acc_mag   = acc_ff[dwsp_pkg::ACC_W-1] ? dwsp_pkg::ACC_W'(-acc_ff) : acc_ff;
   end

   // Results taken from the shared units.
   always_comb begin
      spd_mag = (div_rsp.quo > dwsp_pkg::DIV_N_W'(dwsp_pkg::SPEED_MAX))
              ? dwsp_pkg::SPEED_MAX : div_rsp.quo[dwsp_pkg::SPD_W-1:0];
      acc_add = esum[21] ? -$signed({12'b0, mul_rsp.prod[37:0]})
                         : $signed({12'b0, mul_rsp.prod[37:0]});
      acc_sum = $signed({{2{integ_ff[wheel_ff][dwsp_pkg::ACC_W-1]}}, integ_ff[wheel_ff]})
              + acc_add;
      pm      = dwsp_pkg::TERM_W'(mul_rsp.prod[52:0]) << 1;
      im      = (mul_rsp.prod > dwsp_pkg::TERM_MAX)
              ? dwsp_pkg::TERM_W'(dwsp_pkg::TERM_MAX) : mul_rsp.prod[dwsp_pkg::TERM_W-1:0];
      lim64   = $signed(dwsp_pkg::TERM_W'(lim_eff) << dwsp_pkg::Q25_SHIFT);
      drv_mag = {1'b0, mag_ff[40:dwsp_pkg::Q25_SHIFT]};
      drv_w   = total_ff[dwsp_pkg::TERM_W-1] ? $signed(-drv_mag) : $signed(drv_mag);
      if (total_ff > 0) begin
         dir_w = dwsp_pkg::DIR_FWD;
      end else if (total_ff < 0) begin
         dir_w = dwsp_pkg::DIR_REV;
      end else begin
         dir_w = dwsp_pkg::DIR_OFF;
      end
   end

   // Which unit the current state waits on.
   always_comb begin
      mul_state = (state_ff == dwsp_pkg::ST_DEN) || (state_ff == dwsp_pkg::ST_NUM)
               || (state_ff == dwsp_pkg::ST_ACC) || (state_ff == dwsp_pkg::ST_P)
               || (state_ff == dwsp_pkg::ST_I)   || (state_ff == dwsp_pkg::ST_D)
               || (state_ff == dwsp_pkg::ST_DUTYM);
      div_state = (state_ff == dwsp_pkg::ST_SPD) || (state_ff == dwsp_pkg::ST_DDIV)
               || (state_ff == dwsp_pkg::ST_DUTYD);
      unit_done = (mul_state && mul_rsp.done) || (div_state && div_rsp.done);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dwsp_pkg::ST_IDLE:  if (req_valid) state_in = dwsp_pkg::ST_DEN;
         dwsp_pkg::ST_DEN:   if (unit_done) state_in = dwsp_pkg::ST_NUM;
         dwsp_pkg::ST_NUM:   if (unit_done) state_in = dwsp_pkg::ST_SPD;
         dwsp_pkg::ST_SPD:   if (unit_done) state_in = dwsp_pkg::ST_ACC;
         dwsp_pkg::ST_ACC:   if (unit_done) state_in = dwsp_pkg::ST_P;
         dwsp_pkg::ST_P:     if (unit_done) state_in = dwsp_pkg::ST_I;
         dwsp_pkg::ST_I:     if (unit_done) state_in = dwsp_pkg::ST_D;
         dwsp_pkg::ST_D:     if (unit_done) state_in = dwsp_pkg::ST_DDIV;
         dwsp_pkg::ST_DDIV:  if (unit_done) state_in = dwsp_pkg::ST_SUM;
         dwsp_pkg::ST_SUM:   state_in = dwsp_pkg::ST_CLAMP;
         dwsp_pkg::ST_CLAMP: state_in = dwsp_pkg::ST_DUTYM;
         dwsp_pkg::ST_DUTYM: if (unit_done) state_in = dwsp_pkg::ST_DUTYD;
         dwsp_pkg::ST_DUTYD: if (unit_done) state_in = dwsp_pkg::ST_NEXT;
         dwsp_pkg::ST_NEXT:  state_in = wheel_ff ? dwsp_pkg::ST_OUT : dwsp_pkg::ST_DEN;
         dwsp_pkg::ST_OUT:   if (!rsp_stall) state_in = dwsp_pkg::ST_IDLE;
         default:            state_in = dwsp_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs and unit launches.
   always_comb begin
      req_stall     = (state_ff != dwsp_pkg::ST_IDLE);
      rsp_valid     = (state_ff == dwsp_pkg::ST_OUT);
      mul_req.start = mul_state && !issued_ff;
      div_req.start = div_state && !issued_ff;
      mul_req.a     = '0;
      mul_req.b     = '0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         dwsp_pkg::ST_DEN: begin
            mul_req.a = dwsp_pkg::MUL_A_W'(cpr_eff);
            mul_req.b = dwsp_pkg::MUL_B_W'(ms_ff);
         end
         dwsp_pkg::ST_NUM: begin
            mul_req.a = dwsp_pkg::MUL_A_W'(delta_mag);
            mul_req.b = dwsp_pkg::SPEED_NUM;
         end
         dwsp_pkg::ST_SPD: begin
            div_req.num = dwsp_pkg::DIV_N_W'(num_ff);
            div_req.den = den_ff;
         end
         dwsp_pkg::ST_ACC: begin
            mul_req.a = dwsp_pkg::MUL_A_W'(esum_mag);
            mul_req.b = dwsp_pkg::MUL_B_W'(ms_ff);
         end
         dwsp_pkg::ST_P: begin
            mul_req.a = dwsp_pkg::MUL_A_W'(err_mag);
            mul_req.b = prop_ff;
         end
         dwsp_pkg::ST_I: begin
            mul_req.a = acc_mag;
            mul_req.b = igain_ff;
         end
         dwsp_pkg::ST_D: begin
            mul_req.a = dwsp_pkg::MUL_A_W'(ediff_mag);
            mul_req.b = deriv_ff;
         end
         dwsp_pkg::ST_DDIV: begin
            div_req.num = dwsp_pkg::DIV_N_W'(dmag_ff);
            div_req.den = dwsp_pkg::DIV_D_W'(ms_ff);
         end
         dwsp_pkg::ST_DUTYM: begin
            mul_req.a = dwsp_pkg::MUL_A_W'(mag_ff);
            mul_req.b = dwsp_pkg::MUL_B_W'(dwsp_pkg::DUTY_FULL);
         end
         dwsp_pkg::ST_DUTYD: begin
            div_req.num = dwsp_pkg::DIV_N_W'(dutyn_ff);
            div_req.den = dwsp_pkg::DIV_D_W'(lim_eff);
         end
         default: begin
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      prop_in  = prop_ff;
      igain_in = igain_ff;
      deriv_in = deriv_ff;
      limit_in = limit_ff;
      cpr_l_in = cpr_l_ff;
      cpr_r_in = cpr_r_ff;
      if (csr_wr_en) begin
         case (csr_index)
            dwsp_pkg::CSR_PROP_GAIN:  prop_in  = csr_wdata;
            dwsp_pkg::CSR_INTEG_GAIN: igain_in = csr_wdata;
            dwsp_pkg::CSR_DERIV_GAIN: deriv_in = csr_wdata;
            dwsp_pkg::CSR_DRIVE_LIM:  limit_in = csr_wdata[dwsp_pkg::LIM_W-1:0];
            dwsp_pkg::CSR_CPR_LEFT:   cpr_l_in = csr_wdata[dwsp_pkg::LIM_W-1:0];
            dwsp_pkg::CSR_CPR_RIGHT:  cpr_r_in = csr_wdata[dwsp_pkg::LIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Datapath register updates, step by step.
   always_comb begin
      cnt_l_in  = cnt_l_ff;
      cnt_r_in  = cnt_r_ff;
      tgt_l_in  = tgt_l_ff;
      tgt_r_in  = tgt_r_ff;
      ms_in     = ms_ff;
      last_cnt_in = last_cnt_ff;
      last_err_in = last_err_ff;
      integ_in    = integ_ff;
      wheel_in  = wheel_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      speed_in  = speed_ff;
      acc_in    = acc_ff;
      p_in      = p_ff;
      i_in      = i_ff;
      dmag_in   = dmag_ff;
      dneg_in   = dneg_ff;
      d_in      = d_ff;
      total_in  = total_ff;
      clamp_in  = clamp_ff;
      mag_in    = mag_ff;
      dutyn_in  = dutyn_ff;
      duty_in   = duty_ff;
      drv_l_in  = drv_l_ff;
      drv_r_in  = drv_r_ff;
      dty_l_in  = dty_l_ff;
      dty_r_in  = dty_r_ff;
      dir_l_in  = dir_l_ff;
      dir_r_in  = dir_r_ff;
      spd_l_in  = spd_l_ff;
      spd_r_in  = spd_r_ff;
      issued_in = (state_in != state_ff) ? 1'b0
                : (issued_ff || mul_req.start || div_req.start);
      case (state_ff)
         dwsp_pkg::ST_IDLE: begin
            if (req_valid) begin
               cnt_l_in = req_enc_count_left;
               cnt_r_in = req_enc_count_right;
               tgt_l_in = req_target_rpm_left;
               tgt_r_in = req_target_rpm_right;
               ms_in    = (req_elapsed_ms == '0) ? dwsp_pkg::MS_W'(1) : req_elapsed_ms;
               wheel_in = 1'b0;
            end
         end
         dwsp_pkg::ST_DEN: if (unit_done) den_in = mul_rsp.prod[31:0];
         dwsp_pkg::ST_NUM: if (unit_done) num_in = mul_rsp.prod[55:0];
         dwsp_pkg::ST_SPD: begin
            if (unit_done) begin
               speed_in = delta_neg ? $signed(~spd_mag + 1'b1) : $signed(spd_mag);
            end
         end
         dwsp_pkg::ST_ACC: begin
            if (unit_done) begin
               if (acc_sum > dwsp_pkg::ACC_SAT_HI) begin
                  acc_in = dwsp_pkg::ACC_SAT_HI[dwsp_pkg::ACC_W-1:0];
               end else if (acc_sum < dwsp_pkg::ACC_SAT_LO) begin
                  acc_in = dwsp_pkg::ACC_SAT_LO[dwsp_pkg::ACC_W-1:0];
               end else begin
                  acc_in = acc_sum[dwsp_pkg::ACC_W-1:0];
               end
            end
         end
         dwsp_pkg::ST_P: begin
            if (unit_done) p_in = err_w[dwsp_pkg::ERR_W-1] ? -$signed(pm) : $signed(pm);
         end
         dwsp_pkg::ST_I: begin
            if (unit_done) i_in = acc_ff[dwsp_pkg::ACC_W-1] ? -$signed(im) : $signed(im);
         end
         dwsp_pkg::ST_D: begin
            if (unit_done) begin
               dmag_in = {mul_rsp.prod[53:0], 1'b0};
               dneg_in = ediff[21];
            end
         end
         dwsp_pkg::ST_DDIV: begin
            if (unit_done) d_in = dneg_ff ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);
         end
         dwsp_pkg::ST_SUM: begin
            total_in = p_ff + i_ff + d_ff;
         end
         dwsp_pkg::ST_CLAMP: begin
            // Clamp to the drive limit; the integral is held when this fires.
            clamp_in = 1'b0;
            total_in = total_ff;
            if (total_ff > lim64) begin
               total_in = lim64;
               clamp_in = 1'b1;
            end else if (total_ff < -lim64) begin
               total_in = -lim64;
               clamp_in = 1'b1;
            end
            mag_in = total_in[dwsp_pkg::TERM_W-1] ? 41'(-total_in) : total_in[40:0];
         end
         dwsp_pkg::ST_DUTYM: begin
            if (unit_done) dutyn_in = mul_rsp.prod[48:dwsp_pkg::Q25_SHIFT];
         end
         dwsp_pkg::ST_DUTYD: begin
            if (unit_done) begin
               duty_in = (div_rsp.quo > dwsp_pkg::DIV_N_W'(dwsp_pkg::DUTY_FULL))
                       ? dwsp_pkg::DUTY_FULL : div_rsp.quo[dwsp_pkg::DUTY_W-1:0];
            end
         end
         dwsp_pkg::ST_NEXT: begin
            // Post the wheel's results and advance its state.
            if (wheel_ff) begin
               drv_r_in = drv_w;
               dty_r_in = duty_ff;
               dir_r_in = dir_w;
               spd_r_in = speed_ff;
            end else begin
               drv_l_in = drv_w;
               dty_l_in = duty_ff;
               dir_l_in = dir_w;
               spd_l_in = speed_ff;
            end
            last_cnt_in[wheel_ff] = cnt_sel;
            last_err_in[wheel_ff] = err_w;
            if (!clamp_ff) integ_in[wheel_ff] = acc_ff;
            wheel_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_l_ff <= cnt_l_in;
      cnt_r_ff <= cnt_r_in;
      tgt_l_ff <= tgt_l_in;
      tgt_r_ff <= tgt_r_in;
      ms_ff    <= ms_in;
      den_ff   <= den_in;
      num_ff   <= num_in;
      speed_ff <= speed_in;
      acc_ff   <= acc_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      dmag_ff  <= dmag_in;
      dneg_ff  <= dneg_in;
      d_ff     <= d_in;
      total_ff <= total_in;
      clamp_ff <= clamp_in;
      mag_ff   <= mag_in;
      dutyn_ff <= dutyn_in;
      duty_ff  <= duty_in;
      drv_l_ff <= drv_l_in;
      drv_r_ff <= drv_r_in;
      dty_l_ff <= dty_l_in;
      dty_r_ff <= dty_r_in;
      dir_l_ff <= dir_l_in;
      dir_r_ff <= dir_r_in;
      spd_l_ff <= spd_l_in;
      spd_r_ff <= spd_r_in;
      wheel_ff <= wheel_in;
      if (reset) begin
         state_ff    <= dwsp_pkg::ST_IDLE;
         issued_ff   <= 1'b0;
         prop_ff     <= 32'd1310720;
         igain_ff    <= 32'd9830;
         deriv_ff    <= 32'd0;
         limit_ff    <= 16'd7300;
         cpr_l_ff    <= 16'd149;
         cpr_r_ff    <= 16'd150;
         last_cnt_ff <= '{default: '0};
         last_err_ff <= '{default: '0};
         integ_ff    <= '{default: '0};
      end else begin
         state_ff    <= state_in;
         issued_ff   <= issued_in;
         prop_ff     <= prop_in;
         igain_ff    <= igain_in;
         deriv_ff    <= deriv_in;
         limit_ff    <= limit_in;
         cpr_l_ff    <= cpr_l_in;
         cpr_r_ff    <= cpr_r_in;
         last_cnt_ff <= last_cnt_in;
         last_err_ff <= last_err_in;
         integ_ff    <= integ_in;
      end
   end

   assign rsp_drive_left  = drv_l_ff;
   assign rsp_drive_right = drv_r_ff;
   assign rsp_duty_left   = dty_l_ff;
   assign rsp_duty_right  = dty_r_ff;
   assign rsp_dir_left    = dir_l_ff;
   assign rsp_dir_right   = dir_r_ff;
   assign rsp_speed_left  = spd_l_ff;
   assign rsp_speed_right = spd_r_ff;

   // A response is never offered while a request can be taken.
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("response offered while idle");

   // An accepted request blocks the input on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not blocked after a request");

   // A bridge that is off carries no drive.
   a_off_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dir_left == dwsp_pkg::DIR_OFF) |-> (rsp_drive_left == 0))
      else $error("left drive nonzero with bridge off");

   // Nonzero duty needs a driven bridge.
   a_duty_right: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_duty_right != 0) |-> (rsp_dir_right != dwsp_pkg::DIR_OFF))
      else $error("right duty set with bridge off");

endmodule

`default_nettype wire

@@ rtl/dwsp_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on dwsp_pkg.
`default_nettype none

module dwsp_mul (
   input  wire                        clock,
   input  wire                        reset,
   input  dwsp_pkg::dwsp_mul_req_type req,
   output dwsp_pkg::dwsp_mul_rsp_type rsp
);

   logic [dwsp_pkg::MUL_P_W-1:0]   acc_ff, acc_in;
   logic [dwsp_pkg::MUL_P_W-1:0]   a_sh_ff, a_sh_in;
   logic [dwsp_pkg::MUL_B_W-1:0]   b_sh_ff, b_sh_in;
   logic [dwsp_pkg::MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   // One partial product is added per cycle while the multiplier shifts down.
   always_comb begin
      acc_in  = acc_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = '0;
         a_sh_in = dwsp_pkg::MUL_P_W'(req.a);
         b_sh_in = req.b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_in = acc_ff + a_sh_ff;
         end
         a_sh_in = a_sh_ff << 1;
         b_sh_in = b_sh_ff >> 1;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == dwsp_pkg::MUL_CNT_W'(dwsp_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

`default_nettype wire

@@ rtl/dwsp_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on dwsp_pkg.
`default_nettype none

module dwsp_div (
   input  wire                        clock,
   input  wire                        reset,
   input  dwsp_pkg::dwsp_div_req_type req,
   output dwsp_pkg::dwsp_div_rsp_type rsp
);

   logic [dwsp_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [dwsp_pkg::DIV_D_W-1:0]   den_ff, den_in;
   logic [dwsp_pkg::DIV_N_W-1:0]   num_sh_ff, num_sh_in;
   logic [dwsp_pkg::DIV_N_W-1:0]   quo_ff, quo_in;
   logic [dwsp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [dwsp_pkg::DIV_D_W:0]     trial;
   logic [dwsp_pkg::DIV_D_W:0]     diff;
   logic                           fits;

   // Trial subtraction of the divisor from the partial remainder.
   assign trial = {rem_ff, num_sh_ff[dwsp_pkg::DIV_N_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in    = rem_ff;
      den_in    = den_ff;
      num_sh_in = num_sh_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (req.start) begin
         rem_in    = '0;
         den_in    = req.den;
         num_sh_in = req.num;
         quo_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         rem_in    = fits ? diff[dwsp_pkg::DIV_D_W-1:0] : trial[dwsp_pkg::DIV_D_W-1:0];
         num_sh_in = num_sh_ff << 1;
         quo_in    = {quo_ff[dwsp_pkg::DIV_N_W-2:0], fits};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == dwsp_pkg::DIV_CNT_W'(dwsp_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      num_sh_ff <= num_sh_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

`default_nettype wire
